### sv/int_to_double_pow2_scale_macros.svh
// ---------------------------------------------------------------------------
// int_to_double_pow2_scale_macros
// Assertion macros shared by the conversion block.
// ---------------------------------------------------------------------------
`ifndef INT_TO_DOUBLE_POW2_SCALE_MACROS_SVH
`define INT_TO_DOUBLE_POW2_SCALE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ITD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ITD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/itd_pkg.sv
// ---------------------------------------------------------------------------
// itd_pkg
// Types and constants of the integer to double conversion block.
// ---------------------------------------------------------------------------
package itd_pkg;

    localparam int RawWidth   = 64;
    localparam int ScaleWidth = 11;
    localparam int ScalePos   = 20;
    localparam int MantWidth  = 52;
    localparam int ExpBias    = 1023;

    typedef enum logic [1:0] {
        FMT_S32 = 2'd0,
        FMT_U32 = 2'd1,
        FMT_S64 = 2'd2,
        FMT_U64 = 2'd3
    } fmt_t;

    typedef struct packed {
        logic [63:0] double_bits;
        logic        exp_wrapped;
    } itd_result_t;

endpackage

### sv/itd_convert.sv
// ---------------------------------------------------------------------------
// itd_convert
// Combinational integer to scaled double conversion of one beat.
// ---------------------------------------------------------------------------
module itd_convert
    import itd_pkg::*;
(
    input  logic [1:0]            func,
    input  logic [RawWidth-1:0]   raw_value,
    input  logic [ScaleWidth-1:0] shift_exp,
    output itd_result_t           result
);

    logic [63:0] mag;
    logic        sign;
    logic [5:0]  lead;
    logic        found;
    logic [63:0] norm;
    logic [52:0] mant_trunc;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [53:0] mant_rnd;
    logic [10:0] bexp;
    logic [63:0] bits;
    logic [31:0] hi;
    logic [31:0] scale_ext;
    logic signed [12:0] adj;

    always_comb
    begin
        sign = 1'b0;
        mag  = raw_value;
        case (fmt_t'(func))
            FMT_S32:
            begin
                sign = raw_value[31];
                mag  = {32'd0, raw_value[31] ? (~raw_value[31:0] + 32'd1)
                                            : raw_value[31:0]};
            end
            FMT_U32: mag = {32'd0, raw_value[31:0]};
            FMT_S64:
            begin
                sign = raw_value[63];
                mag  = raw_value[63] ? (~raw_value + 64'd1) : raw_value;
            end
            default: mag = raw_value;
        endcase
    end

    // priority encoder for the leading one
    always_comb
    begin
        lead  = 6'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                lead  = 6'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        norm       = mag << (6'd63 - lead);
        mant_trunc = norm[63:11];
        guard      = norm[10];
        sticky     = |norm[9:0];
        round_up   = guard && (sticky || mant_trunc[0]);
        mant_rnd   = {1'b0, mant_trunc} + {53'd0, round_up};
        bexp       = 11'(ExpBias) + {5'd0, lead} + {10'd0, mant_rnd[53]};
        bits       = {sign, bexp, mant_rnd[53] ? mant_rnd[52:1] : mant_rnd[51:0]};
        scale_ext  = {{(32-ScaleWidth){shift_exp[ScaleWidth-1]}}, shift_exp};
        hi         = bits[63:32] - (scale_ext << ScalePos);
        adj        = $signed({2'b00, bexp}) - 13'(signed'(shift_exp));
        if (!found)
        begin
            result.double_bits = 64'd0;
            result.exp_wrapped = 1'b0;
        end
        else
        begin
            result.double_bits = {hi, bits[31:0]};
            result.exp_wrapped = (adj < 13'sd1) || (adj > 13'sd2046);
        end
    end

endmodule

### sv/int_to_double_pow2_scale.sv
// ---------------------------------------------------------------------------
// int_to_double_pow2_scale
// Signed/unsigned 32/64-bit integer to IEEE 754 double, scaled by 2^-shift_exp.
// ---------------------------------------------------------------------------
// One beat in, one beat out. A beat is registered at the input, converted by
// one pass of combinational logic (negate, leading-one search, normalize,
// round to nearest even, exponent subtract) and held in a result register.
// Throughput is one beat per clock while the output is not stalled. The result
// beat moves from the input register into the result register and is presented
// from there; a stalled output holds it there. The input stage takes a new beat
// whenever it is empty or its beat moves on into the result register, so the
// pipe only holds off when both stages are full and the output is stalled.
// Zero converts to +0.0. exp_wrapped flags an adjusted exponent outside the
// normal range; the pattern then wraps and is not saturated.
module int_to_double_pow2_scale
    import itd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [RawWidth-1:0]   raw_value,
    input  logic [ScaleWidth-1:0] shift_exp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [63:0]           double_bits,
    output logic                  exp_wrapped
);

`include "int_to_double_pow2_scale_macros.svh"

    logic                  s1_valid_reg;
    logic [1:0]            func_reg;
    logic [RawWidth-1:0]   raw_reg;
    logic [ScaleWidth-1:0] shift_reg;
    logic                  out_valid_reg;
    itd_result_t           result_reg;
    itd_result_t           result_next;
    logic                  out_move;
    logic                  s1_move;
    logic                  in_move;

    itd_convert u_convert (
        .func      (func_reg),
        .raw_value (raw_reg),
        .shift_exp (shift_reg),
        .result    (result_next)
    );

    // result register frees when empty or taken
    assign out_move = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_move;
    assign in_stall = s1_valid_reg && !out_move;
    assign in_move  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_move || s1_move)
                s1_valid_reg <= in_move;
            if (out_move)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            func_reg  <= func;
            raw_reg   <= raw_value;
            shift_reg <= shift_exp;
        end
        if (s1_move)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign double_bits = result_reg.double_bits;
    assign exp_wrapped = result_reg.exp_wrapped;

    // a stalled result keeps its beat
    `ITD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)
    // an accepted input lands in the input stage
    `ITD_ASSERT_NEXT(a_fill, clk, rst_n, in_move, s1_valid_reg)
    // input stall only when both stages are full
    `ITD_ASSERT_IMPL(a_stall, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg)

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to double conversion with 2^-n scale.
// A directed table followed by random beats; each output beat is compared against
// a behavioral converter or a hand-computed table result, with random idle and stall phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import itd_pkg::*;

    localparam int NumRandom = 1450;
    localparam int WatchLimit = 5000;

    typedef struct {
        logic [1:0]  fn;
        logic [63:0] raw;
        logic [10:0] sc;
        bit          known;
        logic [63:0] dbl;
        logic        wrp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [63:0] raw_value = '0;
    logic [10:0] shift_exp = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] double_bits;
    logic        exp_wrapped;

    // idle phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int          phase = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;
    int          fails = 0;
    int          quiet = 0;
    itd_result_t pending_results[$];

    always #5 clk = ~clk;

    int_to_double_pow2_scale uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .raw_value   (raw_value),
        .shift_exp   (shift_exp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .double_bits (double_bits),
        .exp_wrapped (exp_wrapped)
    );

    // Behavioral converter: integer to double, round to nearest even above
    // 53 bits, then subtract the scale from the upper word.
    function automatic itd_result_t convert(logic [1:0] fn, logic [63:0] raw,
                                            logic [10:0] sc);
        itd_result_t res;
        logic [63:0] mag;
        logic        neg;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] hi;
        logic [31:0] sc32;
        int          msb;
        int          sh;
        int          bexp;
        int          adj;
        neg = 1'b0;
        case (fmt_t'(fn))
            FMT_S32:
            begin
                neg = raw[31];
                mag = {32'd0, raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0]};
            end
            FMT_U32: mag = {32'd0, raw[31:0]};
            FMT_S64:
            begin
                neg = raw[63];
                mag = raw[63] ? (~raw + 64'd1) : raw;
            end
            default: mag = raw;
        endcase
        res = '0;
        if (mag == 64'd0)
            return res;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (mag[i])
                msb = i;
        bexp = ExpBias + msb;
        if (msb <= MantWidth)
            mant = mag << (MantWidth - msb);
        else
        begin
            sh = msb - MantWidth;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 64'd1;
            if (mant[53])
            begin
                mant = mant >> 1;
                bexp++;
            end
        end
        res.double_bits = {neg, bexp[10:0], mant[51:0]};
        sc32 = {{21{sc[10]}}, sc};
        hi = res.double_bits[63:32] - (sc32 << ScalePos);
        res.double_bits[63:32] = hi;
        adj = bexp - $signed(sc32);
        res.exp_wrapped = (adj < 1 || adj > 2046);
        return res;
    endfunction

    // Directed table. Rows with known set carry hand-computed results.
    stim_row_t dir_rows[] = '{
        '{FMT_S32, 64'h0, 11'd0, 1, 64'h0, 1'b0},
        '{FMT_U64, 64'h0, 11'h3FF, 1, 64'h0, 1'b0},
        '{FMT_U32, 64'hFFFF_FFFF_0000_0000, 11'h400, 1, 64'h0, 1'b0},
        '{FMT_S32, 64'h1, 11'd0, 1, 64'h3FF0_0000_0000_0000, 1'b0},
        '{FMT_S32, 64'hFFFF_FFFF, 11'd0, 1, 64'hBFF0_0000_0000_0000, 1'b0},
        '{FMT_S32, 64'h8000_0000, 11'd0, 1, 64'hC1E0_0000_0000_0000, 1'b0},
        '{FMT_S32, 64'h7FFF_FFFF, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U32, 64'hFFFF_FFFF, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U32, 64'h1, 11'd1, 1, 64'h3FE0_0000_0000_0000, 1'b0},
        '{FMT_S64, 64'h8000_0000_0000_0000, 11'd0, 1, 64'hC3E0_0000_0000_0000, 1'b0},
        '{FMT_S64, 64'h7FFF_FFFF_FFFF_FFFF, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_S64, 64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 1, 64'hBFF0_0000_0000_0000, 1'b0},
        '{FMT_U64, 64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 1, 64'h43F0_0000_0000_0000, 1'b0},
        '{FMT_U64, 64'h0020_0000_0000_0001, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U64, 64'h0020_0000_0000_0003, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U64, 64'h0040_0000_0000_0002, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U64, 64'h0040_0000_0000_0006, 11'd0, 0, 64'h0, 1'b0},
        '{FMT_U32, 64'h1, 11'h3FF, 0, 64'h0, 1'b0},
        '{FMT_U32, 64'h1, 11'h400, 0, 64'h0, 1'b0},
        '{FMT_U32, 64'h1, 11'd1023, 0, 64'h0, 1'b0},
        '{FMT_U64, 64'hFFFF_FFFF_FFFF_FFFF, 11'h400, 0, 64'h0, 1'b0},
        '{FMT_S64, 64'h8000_0000_0000_0000, 11'h7C0, 0, 64'h0, 1'b0},
        '{FMT_S32, 64'hDEAD_BEEF_8000_0001, 11'h5, 0, 64'h0, 1'b0}
    };

    // Offer one beat and hold it until accepted; the table's typed result
    // overrides the converter where given. valid stays high on return so
    // the next beat can follow without a gap.
    task automatic send_beat(logic [1:0] fn, logic [63:0] raw, logic [10:0] sc,
                             bit known, itd_result_t fixed);
        itd_result_t want;
        want = known ? fixed : convert(fn, raw, sc);
        if (phase == 1 || phase == 3)
            while ($urandom_range(99) < ((phase == 3) ? 13 : 56))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid  <= 1'b1;
        func      <= fn;
        raw_value <= raw;
        shift_exp <= sc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    // Random beat: full-range words in half the cases, with narrow magnitudes and
    // rounding-tie patterns mixed in.
    task automatic send_random();
        logic [63:0] raw;
        logic [10:0] sc;
        raw = {$urandom, $urandom};
        case ($urandom_range(5))
            0: raw = raw >> $urandom_range(63);
            1: raw = {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, raw[31:0]};
            2: raw = (raw | 64'h8000_0000_0000_0000) & ~(64'hFFF >> $urandom_range(11));
            default: ;
        endcase
        sc = 11'($urandom);
        if ($urandom_range(3) == 0)
            sc = 11'($signed($urandom_range(40)) - 20);
        send_beat(2'($urandom), raw, sc, 0, '0);
    endtask

    // Receiver stall: random per phase, plus a long hold-off window.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (phase == 2)
            out_stall <= ($urandom_range(99) < 56);
        else if (phase == 3)
            out_stall <= ($urandom_range(99) < 13);
        else
            out_stall <= 1'b0;
    end

    // Output checker: compare every accepted result with the oldest pending one.
    always @(posedge clk)
    begin
        itd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat %h", double_bits);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (double_bits !== want.double_bits)
                begin
                    $error("double_bits expected %h actual %h", want.double_bits,
                           double_bits);
                    fails++;
                end
                if (exp_wrapped !== want.exp_wrapped)
                begin
                    $error("exp_wrapped expected %b actual %b", want.exp_wrapped,
                           exp_wrapped);
                    fails++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Long receiver hold-off, counted here, while the sender keeps offering.
    initial
    begin
        wait (phase == 1);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        itd_result_t fixed;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            fixed.double_bits = dir_rows[i].dbl;
            fixed.exp_wrapped = dir_rows[i].wrp;
            send_beat(dir_rows[i].fn, dir_rows[i].raw, dir_rows[i].sc,
                      dir_rows[i].known, fixed);
        end
        for (int n = 0; n < NumRandom; n++)
        begin
            phase = (n * 4) / NumRandom;
            send_random();
        end
        in_valid <= 1'b0;
        phase = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
